// ===== hdl/frim_pkg.sv =====
// ----------------------------------------------------------------------------
// frim_pkg: shared definitions of the flash record index manager
// Sizes, entry codes, operation and status codes, and the record types.
// ----------------------------------------------------------------------------
package frim_pkg;

  localparam int INDEX_ENTRIES  = 32;
  localparam int BLOCK_BYTES    = 64;    // a power of two
  localparam int MAGIC_BYTES    = 32;
  localparam int SECTOR_BYTES   = 2112;
  localparam int NODE_MAX_BYTES = 2048;
  localparam int HEADER_BYTES   = 2;

  localparam int IDX_W     = $clog2(INDEX_ENTRIES);
  localparam int POS_W     = IDX_W + 1;
  localparam int BYTE_W    = 12;
  localparam int LEN_W     = 16;
  localparam int SOF_W     = LEN_W + 1;
  localparam int BLK_SHIFT = $clog2(BLOCK_BYTES);
  localparam int BASE_BYTES = MAGIC_BYTES + INDEX_ENTRIES;

  localparam logic [7:0] ENTRY_FREE = 8'hFF;
  localparam logic [7:0] ENTRY_CONT = 8'hFE;
  localparam logic [7:0] ENTRY_DEL  = 8'h00;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_DELETE = 2'd1,
    OP_NEXT = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_BIG   = 3'd1,
    ST_NO_ROOM   = 3'd2,
    ST_IDX_FULL  = 3'd3,
    ST_BAD_POS   = 3'd4,
    ST_BAD_TYPE  = 3'd5,
    ST_NONE      = 3'd6,
    ST_RSVD      = 3'd7
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_C_HEAD,
    S_C_BODY,
    S_PLACE,
    S_DEL_HEAD,
    S_DEL_BODY,
    S_NXT_SCAN,
    S_NXT_BODY,
    S_EMIT_MOVE,
    S_EMIT_LAST
  } state_e;

  typedef struct packed {
    logic [7:0]       kind;
    logic [POS_W-1:0] blocks;
    logic [IDX_W-1:0] old_pos;
    logic [IDX_W-1:0] new_pos;
  } move_t;

  // Result item as it sits in tdata, lowest field last.
  typedef struct packed {
    logic              active_side;
    logic [BYTE_W-1:0] free_bytes;
    logic              is_move;
    logic [7:0]        kind_out;
    logic [5:0]        block_count;
    logic [4:0]        old_pos;
    logic [4:0]        record_pos;
    logic [2:0]        status;
  } result_t;

endpackage

// ===== hdl/flash_record_index_manager_top.sv =====
// ----------------------------------------------------------------------------
// flash_record_index_manager_top
// Block-index table of a two-sector flash record store with allocate,
// delete and find-next operations and compaction into the other sector.
// ----------------------------------------------------------------------------
// One request is handled at a time; s_axis_tready is high only while idle.
// All table walks go through one read port of the index table and one
// compare, one entry per cycle. Compaction walks the index entries
// below the first free one, then sends a move item for each record
// that it moved.
// Move items come first, each carrying the free byte count and the active
// sector as they stand after the whole request; the final item has tlast.
module flash_record_index_manager_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // op[1:0], kind_in[9:2], length_in[25:10],
                                        // cursor[31:26]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // status[2:0], record_pos[7:3], old_pos[12:8],
                                        // block_count[18:13], kind_out[26:19],
                                        // is_move[27], free_bytes[39:28],
                                        // active_side[40], zero pad
  output logic        m_axis_tlast_o
);
  import frim_pkg::*;

  localparam logic [POS_W-1:0]  NENT   = POS_W'(INDEX_ENTRIES);
  localparam logic [BYTE_W-1:0] SECT   = BYTE_W'(SECTOR_BYTES);
  localparam logic [BYTE_W-1:0] BASE   = BYTE_W'(BASE_BYTES);
  localparam logic [SOF_W-1:0]  NODE_M = SOF_W'(NODE_MAX_BYTES);

  state_e state_q, state_d;
  logic [7:0]        table_q [INDEX_ENTRIES];
  move_t             mv_q [INDEX_ENTRIES];
  logic [POS_W-1:0]  pos_q, pos_d, dst_q, dst_d, cnt_q, cnt_d, ff_q, ff_d;
  logic [POS_W-1:0]  mv_n_q, mv_n_d, mv_rd_q, mv_rd_d;
  logic [IDX_W-1:0]  head_q, head_d, new_q, new_d;
  logic [7:0]        kind_q, kind_d;
  logic [SOF_W-1:0]  sof_q, sof_d;
  logic [BYTE_W-1:0] used_q, used_d, alloc_q, alloc_d;
  logic              side_q, side_d;
  status_e           rst_q, rst_d;
  logic [IDX_W-1:0]  rpos_q, rpos_d;
  logic [POS_W-1:0]  rblk_q, rblk_d;
  logic [7:0]        rkind_q, rkind_d;
  logic              ovalid_q, ovalid_d, olast_q, olast_d;
  result_t           odata_q, odata_d;

  // Table write controls.
  logic              tw_en, mv_we, tw_clr, tw_place;
  logic [IDX_W-1:0]  tw_addr;
  logic [7:0]        tw_data;

  logic              accept, out_free, in_range, at_end;
  logic [7:0]        ent;
  op_e               in_op;
  logic [7:0]        in_kind;
  logic [LEN_W-1:0]  in_len;
  logic [POS_W-1:0]  in_cur;
  logic [BYTE_W-1:0] room, avail, del_bytes, fb;
  logic [POS_W-1:0]  nb;
  move_t             mv_new, mv_out_q;

  assign in_op   = op_e'(s_axis_tdata_i[1:0]);
  assign in_kind = s_axis_tdata_i[9:2];
  assign in_len  = s_axis_tdata_i[25:10];
  assign in_cur  = s_axis_tdata_i[31:26];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !ovalid_q || m_axis_tready_i;

  assign in_range = (pos_q < NENT);
  assign ent      = in_range ? table_q[pos_q[IDX_W-1:0]] : ENTRY_FREE;
  assign at_end   = !in_range || (ent == ENTRY_FREE);

  assign room  = (used_q < SECT) ? SECT - used_q : '0;
  assign avail = (alloc_q < SECT) ? SECT - alloc_q : '0;
  assign fb    = room;
  assign nb    = POS_W'((sof_q + SOF_W'(BLOCK_BYTES - 1)) >> BLK_SHIFT);
  assign del_bytes = BYTE_W'(cnt_q) << BLK_SHIFT;

  assign mv_new = '{kind: rkind_q, blocks: cnt_q, old_pos: head_q, new_pos: new_q};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_ALLOC:  state_d = S_CHECK;
            OP_DELETE: state_d = (in_cur < NENT) ? S_DEL_HEAD : S_EMIT_LAST;
            OP_NEXT:   state_d = S_NXT_SCAN;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_CHECK: begin
        if (kind_q == ENTRY_DEL || kind_q == ENTRY_CONT || kind_q == ENTRY_FREE ||
            sof_q > NODE_M || sof_q > SOF_W'(room)) begin
          state_d = S_EMIT_LAST;
        end else if (sof_q > SOF_W'(avail)) begin
          state_d = S_C_HEAD;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_C_HEAD: begin
        if (pos_q >= ff_q || at_end) begin
          state_d = S_PLACE;
        end else if (ent != ENTRY_CONT) begin
          state_d = S_C_BODY;
        end
      end
      S_C_BODY: begin
        if (!(in_range && ent == ENTRY_CONT)) state_d = S_C_HEAD;
      end
      S_PLACE:    state_d = S_EMIT_MOVE;
      S_DEL_HEAD: begin
        if (ent == ENTRY_FREE || ent == ENTRY_CONT || ent == ENTRY_DEL) begin
          state_d = S_EMIT_LAST;
        end else begin
          state_d = S_DEL_BODY;
        end
      end
      S_DEL_BODY: begin
        if (!(in_range && ent == ENTRY_CONT)) state_d = S_EMIT_LAST;
      end
      S_NXT_SCAN: begin
        if (at_end) begin
          state_d = S_EMIT_LAST;
        end else if (ent != ENTRY_CONT) begin
          state_d = S_NXT_BODY;
        end
      end
      S_NXT_BODY: begin
        if (!(in_range && ent == ENTRY_CONT)) state_d = S_EMIT_LAST;
      end
      S_EMIT_MOVE: begin
        if (mv_rd_q == mv_n_q) state_d = S_EMIT_LAST;
      end
      S_EMIT_LAST: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    pos_d = pos_q; dst_d = dst_q; cnt_d = cnt_q; ff_d = ff_q;
    mv_n_d = mv_n_q; mv_rd_d = mv_rd_q; head_d = head_q; new_d = new_q;
    kind_d = kind_q; sof_d = sof_q; used_d = used_q; alloc_d = alloc_q;
    side_d = side_q; rst_d = rst_q; rpos_d = rpos_q; rblk_d = rblk_q;
    rkind_d = rkind_q;
    ovalid_d = ovalid_q && !m_axis_tready_i;
    olast_d = olast_q; odata_d = odata_q;
    tw_en = 1'b0; tw_addr = '0; tw_data = ENTRY_DEL;
    tw_clr = 1'b0; tw_place = 1'b0; mv_we = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_d = in_kind;
          sof_d = SOF_W'(in_len) + SOF_W'(HEADER_BYTES);
          pos_d = in_cur;
          mv_n_d = '0;
          mv_rd_d = '0;
          rst_d = ST_OK; rpos_d = '0; rblk_d = '0; rkind_d = '0;
          if (in_op == OP_DELETE && in_cur >= NENT) rst_d = ST_BAD_POS;
        end
      end
      S_CHECK: begin
        if (kind_q == ENTRY_DEL || kind_q == ENTRY_CONT || kind_q == ENTRY_FREE) begin
          rst_d = ST_BAD_TYPE;
        end else if (sof_q > NODE_M) begin
          rst_d = ST_TOO_BIG;
        end else if (sof_q > SOF_W'(room)) begin
          rst_d = ST_NO_ROOM;
        end
        pos_d = '0;
        dst_d = '0;
      end
      S_C_HEAD: begin
        if (pos_q >= ff_q || at_end) begin
          tw_clr = 1'b1;
          ff_d = dst_q;
          used_d = BASE + (BYTE_W'(dst_q) << BLK_SHIFT);
          alloc_d = BASE + (BYTE_W'(dst_q) << BLK_SHIFT);
          side_d = !side_q;
        end else if (ent == ENTRY_CONT) begin
          pos_d = pos_q + 1'b1;
        end else begin
          rkind_d = ent;
          head_d = pos_q[IDX_W-1:0];
          new_d = dst_q[IDX_W-1:0];
          cnt_d = POS_W'(1);
          pos_d = pos_q + 1'b1;
          if (ent != ENTRY_DEL) begin
            tw_en = 1'b1; tw_addr = dst_q[IDX_W-1:0]; tw_data = ent;
            dst_d = dst_q + 1'b1;
          end
        end
      end
      S_C_BODY: begin
        if (in_range && ent == ENTRY_CONT) begin
          cnt_d = cnt_q + 1'b1;
          pos_d = pos_q + 1'b1;
          if (rkind_q != ENTRY_DEL) begin
            tw_en = 1'b1; tw_addr = dst_q[IDX_W-1:0]; tw_data = ENTRY_CONT;
            dst_d = dst_q + 1'b1;
          end
        end else if (rkind_q != ENTRY_DEL) begin
          mv_we = 1'b1;
          mv_n_d = mv_n_q + 1'b1;
        end
      end
      S_PLACE: begin
        if (ff_q >= NENT || nb > NENT - ff_q) begin
          rst_d = ST_IDX_FULL;
          rpos_d = '0; rblk_d = '0; rkind_d = '0;
        end else begin
          tw_place = 1'b1;
          rst_d = ST_OK;
          rpos_d = ff_q[IDX_W-1:0];
          rblk_d = nb;
          rkind_d = kind_q;
          ff_d = ff_q + nb;
          used_d = used_q + (BYTE_W'(nb) << BLK_SHIFT);
          alloc_d = alloc_q + (BYTE_W'(nb) << BLK_SHIFT);
        end
      end
      S_DEL_HEAD: begin
        if (ent == ENTRY_FREE || ent == ENTRY_CONT || ent == ENTRY_DEL) begin
          rst_d = ST_BAD_POS;
        end else begin
          tw_en = 1'b1; tw_addr = pos_q[IDX_W-1:0]; tw_data = ENTRY_DEL;
          rpos_d = pos_q[IDX_W-1:0];
          cnt_d = POS_W'(1);
          pos_d = pos_q + 1'b1;
        end
      end
      S_DEL_BODY: begin
        if (in_range && ent == ENTRY_CONT) begin
          tw_en = 1'b1; tw_addr = pos_q[IDX_W-1:0]; tw_data = ENTRY_DEL;
          cnt_d = cnt_q + 1'b1;
          pos_d = pos_q + 1'b1;
        end else begin
          used_d = (used_q > del_bytes) ? used_q - del_bytes : '0;
          rblk_d = cnt_q;
        end
      end
      S_NXT_SCAN: begin
        if (at_end) begin
          rst_d = ST_NONE;
        end else if (ent == ENTRY_CONT) begin
          pos_d = pos_q + 1'b1;
        end else begin
          rpos_d = pos_q[IDX_W-1:0];
          rkind_d = ent;
          cnt_d = POS_W'(1);
          pos_d = pos_q + 1'b1;
        end
      end
      S_NXT_BODY: begin
        if (in_range && ent == ENTRY_CONT) begin
          cnt_d = cnt_q + 1'b1;
          pos_d = pos_q + 1'b1;
        end else begin
          rblk_d = cnt_q;
        end
      end
      S_EMIT_MOVE: begin
        if (mv_rd_q != mv_n_q && out_free) begin
          ovalid_d = 1'b1;
          olast_d = 1'b0;
          odata_d = '{active_side: side_q, free_bytes: fb, is_move: 1'b1,
                      kind_out: mv_out_q.kind, block_count: 6'(mv_out_q.blocks),
                      old_pos: 5'(mv_out_q.old_pos), record_pos: 5'(mv_out_q.new_pos),
                      status: ST_OK};
          mv_rd_d = mv_rd_q + 1'b1;
        end
      end
      S_EMIT_LAST: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          olast_d = 1'b1;
          odata_d = '{active_side: side_q, free_bytes: fb, is_move: 1'b0,
                      kind_out: rkind_q, block_count: 6'(rblk_q), old_pos: '0,
                      record_pos: 5'(rpos_q), status: rst_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ff_q <= '0;
      used_q <= BASE;
      alloc_q <= BASE;
      side_q <= 1'b0;
      ovalid_q <= 1'b0;
      mv_n_q <= '0;
      mv_rd_q <= '0;
      pos_q <= '0;
      dst_q <= '0;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      ff_q <= ff_d;
      used_q <= used_d;
      alloc_q <= alloc_d;
      side_q <= side_d;
      ovalid_q <= ovalid_d;
      mv_n_q <= mv_n_d;
      mv_rd_q <= mv_rd_d;
      pos_q <= pos_d;
      dst_q <= dst_d;
      cnt_q <= cnt_d;
    end
  end

  // The move list is read one entry ahead, so the entry at the read pointer
  // is ready in a register when it is sent.
  always_ff @(posedge clk_i) begin
    head_q <= head_d; new_q <= new_d; kind_q <= kind_d; sof_q <= sof_d;
    rst_q <= rst_d; rpos_q <= rpos_d; rblk_q <= rblk_d; rkind_q <= rkind_d;
    olast_q <= olast_d; odata_q <= odata_d;
    if (mv_we) mv_q[mv_n_q[IDX_W-1:0]] <= mv_new;
    mv_out_q <= mv_q[mv_rd_d[IDX_W-1:0]];
  end

  // Index table: one entry write per cycle, plus the tail clear that ends a
  // compaction and the block-wide write that places a new record.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < INDEX_ENTRIES; i++) table_q[i] <= ENTRY_FREE;
    end else begin
      for (int i = 0; i < INDEX_ENTRIES; i++) begin
        if (tw_clr && POS_W'(i) >= dst_q) begin
          table_q[i] <= ENTRY_FREE;
        end else if (tw_place && POS_W'(i) >= ff_q && POS_W'(i) < ff_q + nb) begin
          table_q[i] <= (POS_W'(i) == ff_q) ? kind_q : ENTRY_CONT;
        end else if (tw_en && tw_addr == IDX_W'(i)) begin
          table_q[i] <= tw_data;
        end
      end
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tlast_o  = olast_q;
  assign m_axis_tdata_o  = {7'b0, odata_q};

endmodule

// ===== hdl/frim_checker.sv =====
// ----------------------------------------------------------------------------
// frim_checker: port-level checks of the flash record index manager
// Watches the stream ports and flags results that break the block's rules.
// ----------------------------------------------------------------------------
module frim_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [31:0] s_axis_tdata_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [47:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);
  import frim_pkg::*;

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && m_axis_tvalid_o)
    else $error("result changed while stalled");

  // A move item is never the final item of a request.
  a_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[27] |-> !m_axis_tlast_o)
    else $error("move item marked last");

  // Status codes stay within the defined set.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[2:0] != ST_RSVD)
    else $error("reserved status code");

  // A real request keeps the input closed in the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tdata_i[1:0] != OP_NONE
    |=> !s_axis_tready_o)
    else $error("input open during a request");

endmodule

bind flash_record_index_manager_top frim_checker u_frim_checker (.*);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the flash record index manager
// Drives allocate, delete and find-next requests over the input stream and
// checks each result item against a local model of the index table, with
// random idling on both sides of the block.
// ----------------------------------------------------------------------------
module tb_top;
  import frim_pkg::*;

  typedef struct {
    logic [2:0] status;
    logic [4:0] record_pos;
    logic [4:0] old_pos;
    logic [5:0] block_count;
    logic [7:0] kind_out;
    logic       is_move;
    logic [11:0] free_bytes;
    logic       active_side;
    logic       last;
  } rec_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [47:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  flash_record_index_manager_top DUT (.*);

  // Local copy of the index state.
  logic [7:0]  idx_tbl [INDEX_ENTRIES];
  int unsigned used_b, alloc_b, first_free;
  logic        side;

  rec_result_t expected_q[$];
  rec_result_t step_q[$];
  int          send_idle_pct, recv_idle_pct;
  int          errors;
  longint      cycles;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("flash_record_index_manager_top verification failed");
      $finish;
    end
  end

  function automatic int unsigned run_len(int unsigned pos);
    int unsigned p;
    p = pos + 1;
    while (p < INDEX_ENTRIES && idx_tbl[p] == ENTRY_CONT) p++;
    return p - pos;
  endfunction

  function automatic void push_res(logic [2:0] st, int unsigned rp, int unsigned op,
                                   int unsigned bc, logic [7:0] k, logic mv, logic lst);
    rec_result_t r;
    r.status = st; r.record_pos = rp[4:0]; r.old_pos = op[4:0];
    r.block_count = bc[5:0]; r.kind_out = k; r.is_move = mv; r.last = lst;
    r.free_bytes = '0; r.active_side = 1'b0;
    step_q.push_back(r);
  endfunction

  function automatic void compact_sector();
    logic [7:0]  fresh [INDEX_ENTRIES];
    int unsigned dst, pos, b;
    logic [7:0]  t;
    dst = 0; pos = 0;
    foreach (fresh[i]) fresh[i] = ENTRY_FREE;
    while (pos < first_free && pos < INDEX_ENTRIES) begin
      t = idx_tbl[pos];
      if (t == ENTRY_FREE) break;
      if (t == ENTRY_CONT) begin
        pos++;
        continue;
      end
      b = run_len(pos);
      if (t != ENTRY_DEL) begin
        fresh[dst] = t;
        for (int i = 1; i < b; i++) fresh[dst + i] = ENTRY_CONT;
        push_res(ST_OK, dst, pos, b, t, 1'b1, 1'b0);
        dst += b;
      end
      pos += b;
    end
    idx_tbl = fresh;
    used_b = BASE_BYTES + dst * BLOCK_BYTES;
    alloc_b = used_b;
    first_free = dst;
    side = ~side;
  endfunction

  function automatic void predict_alloc(logic [7:0] k, int unsigned len);
    int unsigned sof, room, avail, nb;
    sof = len + HEADER_BYTES;
    if (k == ENTRY_DEL || k == ENTRY_CONT || k == ENTRY_FREE) begin
      push_res(ST_BAD_TYPE, 0, 0, 0, 0, 0, 1); return;
    end
    if (sof > NODE_MAX_BYTES) begin
      push_res(ST_TOO_BIG, 0, 0, 0, 0, 0, 1); return;
    end
    room = used_b < SECTOR_BYTES ? SECTOR_BYTES - used_b : 0;
    if (sof > room) begin
      push_res(ST_NO_ROOM, 0, 0, 0, 0, 0, 1); return;
    end
    avail = alloc_b < SECTOR_BYTES ? SECTOR_BYTES - alloc_b : 0;
    if (sof > avail) compact_sector();
    nb = (sof + BLOCK_BYTES - 1) / BLOCK_BYTES;
    if (first_free >= INDEX_ENTRIES || nb > INDEX_ENTRIES - first_free) begin
      push_res(ST_IDX_FULL, 0, 0, 0, 0, 0, 1); return;
    end
    idx_tbl[first_free] = k;
    for (int i = 1; i < nb; i++) idx_tbl[first_free + i] = ENTRY_CONT;
    push_res(ST_OK, first_free, 0, nb, k, 0, 1);
    first_free += nb;
    used_b += nb * BLOCK_BYTES;
    alloc_b += nb * BLOCK_BYTES;
  endfunction

  function automatic void predict_delete(int unsigned pos);
    logic [7:0]  t;
    int unsigned b, bytes;
    if (pos >= INDEX_ENTRIES) begin
      push_res(ST_BAD_POS, 0, 0, 0, 0, 0, 1); return;
    end
    t = idx_tbl[pos];
    if (t == ENTRY_FREE || t == ENTRY_CONT || t == ENTRY_DEL) begin
      push_res(ST_BAD_POS, 0, 0, 0, 0, 0, 1); return;
    end
    b = run_len(pos);
    for (int i = 0; i < b; i++) idx_tbl[pos + i] = ENTRY_DEL;
    bytes = b * BLOCK_BYTES;
    used_b = used_b > bytes ? used_b - bytes : 0;
    push_res(ST_OK, pos, 0, b, ENTRY_DEL, 0, 1);
  endfunction

  function automatic void predict_next(int unsigned pos);
    while (pos < INDEX_ENTRIES) begin
      if (idx_tbl[pos] == ENTRY_FREE) break;
      if (idx_tbl[pos] != ENTRY_CONT) begin
        push_res(ST_OK, pos, 0, run_len(pos), idx_tbl[pos], 0, 1); return;
      end
      pos++;
    end
    push_res(ST_NONE, 0, 0, 0, 0, 0, 1);
  endfunction

  // Updates the table model and queues every result item of one request.
  function automatic void predict_request(op_e op, logic [7:0] k, logic [15:0] len,
                                          logic [5:0] cur);
    int unsigned fb;
    step_q.delete();
    case (op)
      OP_ALLOC:  predict_alloc(k, len);
      OP_DELETE: predict_delete(cur);
      OP_NEXT:   predict_next(cur);
      default: ;
    endcase
    fb = used_b < SECTOR_BYTES ? SECTOR_BYTES - used_b : 0;
    foreach (step_q[i]) begin
      step_q[i].free_bytes = fb[11:0];
      step_q[i].active_side = side;
      expected_q.push_back(step_q[i]);
    end
  endfunction

  // The valid line stays as it is after an accept; the next call or the
  // drain task decides what it shows from then on.
  task automatic send_request(op_e op, logic [7:0] k, logic [15:0] len, logic [5:0] cur);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {cur, len, k, op};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_request(op, k, len, cur);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni)
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checker.
  always @(posedge clk_i) begin
    rec_result_t e;
    logic [47:0] d;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      d = m_axis_tdata_o;
      if (expected_q.size() == 0) begin
        $error("unexpected result item %h", d);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (d[2:0] !== e.status) begin
          $error("status exp %0d got %0d", e.status, d[2:0]); errors++;
        end
        if (d[7:3] !== e.record_pos) begin
          $error("record_pos exp %0d got %0d", e.record_pos, d[7:3]); errors++;
        end
        if (d[12:8] !== e.old_pos) begin
          $error("old_pos exp %0d got %0d", e.old_pos, d[12:8]); errors++;
        end
        if (d[18:13] !== e.block_count) begin
          $error("block_count exp %0d got %0d", e.block_count, d[18:13]); errors++;
        end
        if (d[26:19] !== e.kind_out) begin
          $error("kind_out exp %0h got %0h", e.kind_out, d[26:19]); errors++;
        end
        if (d[27] !== e.is_move) begin
          $error("is_move exp %0b got %0b", e.is_move, d[27]); errors++;
        end
        if (d[39:28] !== e.free_bytes) begin
          $error("free_bytes exp %0d got %0d", e.free_bytes, d[39:28]); errors++;
        end
        if (d[40] !== e.active_side) begin
          $error("active_side exp %0b got %0b", e.active_side, d[40]); errors++;
        end
        if (m_axis_tlast_o !== e.last) begin
          $error("last exp %0b got %0b", e.last, m_axis_tlast_o); errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_request(OP_NEXT, 8'h00, 16'd0, 6'd0);          // empty table
    send_request(OP_ALLOC, ENTRY_DEL, 16'd0, 6'd0);     // bad types
    send_request(OP_ALLOC, ENTRY_CONT, 16'd0, 6'd0);
    send_request(OP_ALLOC, ENTRY_FREE, 16'd0, 6'd0);
    send_request(OP_ALLOC, 8'h01, 16'hFFFF, 6'd0);      // too big
    send_request(OP_ALLOC, 8'h01, 16'd2047, 6'd0);      // just too big
    send_request(OP_ALLOC, 8'h01, 16'd0, 6'd0);
    send_request(OP_ALLOC, 8'h7F, 16'd200, 6'd0);
    send_request(OP_ALLOC, 8'hFD, 16'd62, 6'd0);
    send_request(OP_NONE, 8'hAA, 16'hAAAA, 6'h2A);      // ignored
    send_request(OP_NEXT, 8'h00, 16'd0, 6'd2);          // lands on continuation
    send_request(OP_DELETE, 8'h00, 16'd0, 6'd1);
    send_request(OP_DELETE, 8'h00, 16'd0, 6'd1);        // already deleted
    send_request(OP_DELETE, 8'h00, 16'd0, 6'd2);        // inside the deleted record
    send_request(OP_DELETE, 8'h00, 16'd0, 6'd31);       // free
    send_request(OP_DELETE, 8'h00, 16'd0, 6'd63);       // past index
    send_request(OP_NEXT, 8'h00, 16'd0, 6'd1);          // finds deleted
    send_request(OP_NEXT, 8'h00, 16'd0, 6'd63);
    send_request(OP_ALLOC, 8'h55, 16'd2046, 6'd0);      // no room
    send_request(OP_ALLOC, 8'h66, 16'd2046, 6'd0);      // no room
    for (int i = 0; i < 5; i++) send_request(OP_ALLOC, 8'h10, 16'd0, 6'd0);
    wait_drained();
  endtask

  task automatic test_random(int n);
    op_e op;
    int  r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      op = r < 50 ? OP_ALLOC : r < 75 ? OP_DELETE : r < 97 ? OP_NEXT : OP_NONE;
      if (op == OP_ALLOC && $urandom_range(9) != 0)
        send_request(op, 8'($urandom_range(1, 253)), 16'($urandom_range(0, 300)),
                     6'($urandom));
      else if (op != OP_ALLOC && $urandom_range(3) != 0)
        send_request(op, 8'($urandom), 16'($urandom),
                     6'($urandom_range(0, INDEX_ENTRIES - 1)));
      else
        send_request(op, 8'($urandom), 16'($urandom), 6'($urandom));
      if (i == n / 2) wait_drained();   // sender pause
    end
    wait_drained();
  endtask

  initial begin
    int guard;
    errors = 0; cycles = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    m_axis_tready_i = 1'b0;
    foreach (idx_tbl[i]) idx_tbl[i] = ENTRY_FREE;
    used_b = BASE_BYTES; alloc_b = BASE_BYTES; first_free = 0; side = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 38; recv_idle_pct = 66;
    test_directed();
    test_random(110);
    send_idle_pct = 66; recv_idle_pct = 38;
    test_random(110);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(120);
    guard = 0;
    while (expected_q.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (100) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0)
      $display("flash_record_index_manager_top verification clean");
    else
      $display("flash_record_index_manager_top verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/frim_pkg.sv
hdl/flash_record_index_manager_top.sv
hdl/frim_checker.sv
sim/tb_top.sv
